// ===== rtl/core/pgss_pkg.sv =====
// Package for the pedal and gear speed setpoint block.
// Holds the register map, gear codes, reset values and the pedal percent function.
// No dependencies.
package pgss_pkg;

    typedef logic [1:0] gear_t;

    localparam gear_t GEAR_NEUTRAL = 2'd0;
    localparam gear_t GEAR_FIRST   = 2'd1;
    localparam gear_t GEAR_SECOND  = 2'd2;

    typedef logic [2:0] reg_index_t;

    localparam reg_index_t REG_NEUTRAL_DECAY = 3'd0;
    localparam reg_index_t REG_FIRST_GAIN    = 3'd1;
    localparam reg_index_t REG_SECOND_GAIN   = 3'd2;
    localparam reg_index_t REG_BRAKE_GAIN    = 3'd3;
    localparam reg_index_t REG_FIRST_LIMIT   = 3'd4;
    localparam reg_index_t REG_SECOND_LIMIT  = 3'd5;

    localparam logic [11:0] RST_NEUTRAL_DECAY = 12'd400;
    localparam logic [7:0]  RST_FIRST_GAIN    = 8'd16;
    localparam logic [7:0]  RST_SECOND_GAIN   = 8'd24;
    localparam logic [7:0]  RST_BRAKE_GAIN    = 8'd32;
    localparam logic [17:0] RST_FIRST_LIMIT   = 18'd80000;
    localparam logic [17:0] RST_SECOND_LIMIT  = 18'd200000;

    localparam logic [6:0]  PCT_MAX     = 7'd100;
    localparam logic [18:0] PCT_SCALE   = 19'd100;
    localparam logic [18:0] FULL_SCALE  = 19'd4081;
    // 257 / 2^20 sits just above 1 / 4081: the estimate is exact or one high
    localparam logic [27:0] PCT_RECIP   = 28'd257;

    // floor(raw * 100 / 4081), saturated at 100
    function automatic logic [6:0] to_percent(input logic [11:0] raw);
        logic [18:0] scaled;
        logic [27:0] est;
        logic [6:0]  p;
        logic [18:0] back;
        scaled = 19'(raw) * PCT_SCALE;
        est    = 28'(scaled) * PCT_RECIP;
        p      = est[26:20];
        back   = 19'(p) * FULL_SCALE;
        if (back > scaled)
        begin
            p = p - 7'd1;
        end
        if (p > PCT_MAX)
        begin
            p = PCT_MAX;
        end
        return p;
    endfunction

endpackage

// ===== rtl/core/pedal_gear_speed_setpoint_top.sv =====
// Each result is held in the output register, after the input, sum and average registers.
// Throughput: one item per cycle unless m_tready stalls; one result per WINDOW items.
// Stages: input register, percent and window sums, window averages, speed update.
// Reset (rst_n, asynchronous, active low) clears sums, count, kept speed and valid flags,
// and loads the configuration registers with their default values.
// Top level of the pedal and gear speed setpoint block.
// Depends on pgss_pkg.
module pedal_gear_speed_setpoint_top
    import pgss_pkg::*;
#(
    parameter int WINDOW = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // s_tdata: brake_raw[11:0], throttle_raw[23:12], neutral_pin[24], second_pin[25], zero
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    // m_tdata: speed[17:0], brake_average[24:18], throttle_average[31:25], gear_used[33:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CNT_W = $clog2(WINDOW);
    localparam int SUM_W = $clog2(100 * WINDOW + 1);
    localparam int SH    = SUM_W + 1;
    localparam int RECIP = (2 ** SH) / WINDOW;
    localparam logic [CNT_W-1:0] LAST_C  = CNT_W'(WINDOW - 1);
    localparam logic [SUM_W:0]   WIN_C   = (SUM_W + 1)'(WINDOW);
    localparam logic [SUM_W+SH-1:0] RECIP_C = (SUM_W + SH)'(RECIP);

    // floor(sum / WINDOW): reciprocal estimate, low by at most one, then correct
    function automatic logic [6:0] window_avg(input logic [SUM_W-1:0] sum);
        logic [SUM_W+SH-1:0] prod;
        logic [SUM_W-1:0]    q;
        logic [SUM_W:0]      back;
        logic [SUM_W:0]      rem;
        prod = (SUM_W + SH)'(sum) * RECIP_C;
        q    = prod[SUM_W+SH-1:SH];
        back = (SUM_W + 1)'(q) * WIN_C;
        rem  = {1'b0, sum} - back;
        if (rem >= WIN_C)
        begin
            q = q + 1'b1;
        end
        return q[6:0];
    endfunction

    // configuration registers
    logic [11:0] neutral_decay_reg;
    logic [7:0]  first_gain_reg;
    logic [7:0]  second_gain_reg;
    logic [7:0]  brake_gain_reg;
    logic [17:0] first_limit_reg;
    logic [17:0] second_limit_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neutral_decay_reg <= RST_NEUTRAL_DECAY;
            first_gain_reg    <= RST_FIRST_GAIN;
            second_gain_reg   <= RST_SECOND_GAIN;
            brake_gain_reg    <= RST_BRAKE_GAIN;
            first_limit_reg   <= RST_FIRST_LIMIT;
            second_limit_reg  <= RST_SECOND_LIMIT;
        end
        else if (cfg_write)
        begin
            unique case (paddr[4:2])
                REG_NEUTRAL_DECAY: neutral_decay_reg <= pwdata[11:0];
                REG_FIRST_GAIN:    first_gain_reg    <= pwdata[7:0];
                REG_SECOND_GAIN:   second_gain_reg   <= pwdata[7:0];
                REG_BRAKE_GAIN:    brake_gain_reg    <= pwdata[7:0];
                REG_FIRST_LIMIT:   first_limit_reg   <= pwdata[17:0];
                REG_SECOND_LIMIT:  second_limit_reg  <= pwdata[17:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_NEUTRAL_DECAY: prdata = {20'd0, neutral_decay_reg};
            REG_FIRST_GAIN:    prdata = {24'd0, first_gain_reg};
            REG_SECOND_GAIN:   prdata = {24'd0, second_gain_reg};
            REG_BRAKE_GAIN:    prdata = {24'd0, brake_gain_reg};
            REG_FIRST_LIMIT:   prdata = {14'd0, first_limit_reg};
            REG_SECOND_LIMIT:  prdata = {14'd0, second_limit_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // stage flow
    logic in_valid_reg;
    logic win_valid_reg;
    logic avg_valid_reg;
    logic out_valid_reg;
    logic in_last;
    logic in_go;
    logic win_move;
    logic avg_move;
    logic out_free;
    logic avg_free;
    logic win_free;
    logic s_take;

    assign out_free = !out_valid_reg || m_tready;
    assign avg_move = avg_valid_reg && out_free;
    assign avg_free = !avg_valid_reg || avg_move;
    assign win_move = win_valid_reg && avg_free;
    assign win_free = !win_valid_reg || win_move;
    assign in_go    = in_valid_reg && (!in_last || win_free);
    assign s_tready = !in_valid_reg || in_go;
    assign s_take   = s_tvalid && s_tready;

    // input register
    logic [11:0] brake_raw_reg;
    logic [11:0] throttle_raw_reg;
    logic        neutral_pin_reg;
    logic        second_pin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (in_go)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            brake_raw_reg    <= s_tdata[11:0];
            throttle_raw_reg <= s_tdata[23:12];
            neutral_pin_reg  <= s_tdata[24];
            second_pin_reg   <= s_tdata[25];
        end
    end

    // percent and window sums
    logic [CNT_W-1:0] count_reg;
    logic [SUM_W-1:0] brake_sum_reg;
    logic [SUM_W-1:0] throttle_sum_reg;
    logic [SUM_W-1:0] brake_sum_next;
    logic [SUM_W-1:0] throttle_sum_next;
    logic [SUM_W-1:0] win_brake_reg;
    logic [SUM_W-1:0] win_throttle_reg;
    gear_t            gear_in;
    gear_t            win_gear_reg;

    assign in_last           = (count_reg == LAST_C);
    assign brake_sum_next    = brake_sum_reg + SUM_W'(to_percent(brake_raw_reg));
    assign throttle_sum_next = throttle_sum_reg + SUM_W'(to_percent(throttle_raw_reg));

    always_comb
    begin
        if (neutral_pin_reg)
        begin
            gear_in = GEAR_NEUTRAL;
        end
        else if (second_pin_reg)
        begin
            gear_in = GEAR_SECOND;
        end
        else
        begin
            gear_in = GEAR_FIRST;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            brake_sum_reg    <= '0;
            throttle_sum_reg <= '0;
        end
        else if (in_go)
        begin
            if (in_last)
            begin
                count_reg        <= '0;
                brake_sum_reg    <= '0;
                throttle_sum_reg <= '0;
            end
            else
            begin
                count_reg        <= count_reg + 1'b1;
                brake_sum_reg    <= brake_sum_next;
                throttle_sum_reg <= throttle_sum_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_valid_reg <= 1'b0;
        end
        else if (in_go && in_last)
        begin
            win_valid_reg <= 1'b1;
        end
        else if (win_move)
        begin
            win_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_go && in_last)
        begin
            win_brake_reg    <= brake_sum_next;
            win_throttle_reg <= throttle_sum_next;
            win_gear_reg     <= gear_in;
        end
    end

    // window averages
    logic [6:0] avg_brake_reg;
    logic [6:0] avg_throttle_reg;
    gear_t      avg_gear_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_valid_reg <= 1'b0;
        end
        else if (win_move)
        begin
            avg_valid_reg <= 1'b1;
        end
        else if (avg_move)
        begin
            avg_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (win_move)
        begin
            avg_brake_reg    <= window_avg(win_brake_reg);
            avg_throttle_reg <= window_avg(win_throttle_reg);
            avg_gear_reg     <= win_gear_reg;
        end
    end

    // speed update
    logic [17:0]        speed_now_reg;
    logic [17:0]        speed_next;
    logic [7:0]         gain;
    logic [17:0]        limit;
    logic [14:0]        up_prod;
    logic [14:0]        down_prod;
    logic signed [19:0] base;
    logic signed [19:0] moved;

    assign gain      = (avg_gear_reg == GEAR_SECOND) ? second_gain_reg : first_gain_reg;
    assign limit     = (avg_gear_reg == GEAR_SECOND) ? second_limit_reg : first_limit_reg;
    assign up_prod   = 15'(gain) * 15'(avg_throttle_reg);
    assign down_prod = 15'(brake_gain_reg) * 15'(avg_brake_reg);
    assign base      = signed'({2'b00, speed_now_reg});

    always_comb
    begin
        moved = base;
        if (avg_gear_reg == GEAR_NEUTRAL)
        begin
            moved = base - signed'({8'd0, neutral_decay_reg});
        end
        else if (avg_brake_reg == 7'd0 && avg_throttle_reg != 7'd0)
        begin
            moved = base + signed'({5'd0, up_prod});
        end
        else if (avg_brake_reg != 7'd0 && avg_throttle_reg == 7'd0)
        begin
            moved = base - signed'({5'd0, down_prod});
        end

        if (moved < 20'sd0)
        begin
            speed_next = '0;
        end
        else if (avg_gear_reg != GEAR_NEUTRAL && moved > signed'({2'b00, limit}))
        begin
            speed_next = limit;
        end
        else
        begin
            speed_next = moved[17:0];
        end
    end

    logic [6:0] out_brake_reg;
    logic [6:0] out_throttle_reg;
    gear_t      out_gear_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_now_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (avg_move)
            begin
                speed_now_reg <= speed_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (avg_move)
        begin
            out_brake_reg    <= avg_brake_reg;
            out_throttle_reg <= avg_throttle_reg;
            out_gear_reg     <= avg_gear_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_gear_reg, out_throttle_reg, out_brake_reg, speed_now_reg};

`ifndef SYNTH
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LAST_C)
        else $error("window count beyond window");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_go && in_last && win_valid_reg && !win_move))
        else $error("window sums overwritten");

    a_avg_range: assert property (@(posedge clk) disable iff (!rst_n)
        avg_valid_reg |-> (avg_brake_reg <= PCT_MAX && avg_throttle_reg <= PCT_MAX))
        else $error("average above full scale");

    a_gear_limit: assert property (@(posedge clk) disable iff (!rst_n)
        avg_move && avg_gear_reg != GEAR_NEUTRAL |=> speed_now_reg <= $past(limit))
        else $error("speed above gear limit");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |=> $stable(speed_now_reg))
        else $error("kept speed changed while result waits");
`endif

endmodule

// ===== tb/pedal_gear_speed_setpoint_monitor.sv =====
`timescale 1ns / 1ps
// Monitor for the pedal and gear speed setpoint block: tracks register writes, checks
// register reads, predicts each window's speed update from accepted samples and checks results.
// Depends on pgss_pkg.
module pedal_gear_speed_setpoint_monitor
    import pgss_pkg::*;
#(
    parameter int WINDOW = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending,
    output int          samples_taken,
    output int          results_checked
);

    localparam int unsigned PEDAL_FULL_SCALE = 4081;
    localparam int unsigned PEDAL_PCT_TOP    = 100;

    typedef struct {
        logic [17:0] speed;
        logic [6:0]  brake_avg;
        logic [6:0]  throttle_avg;
        gear_t       gear;
    } setpoint_t;

    setpoint_t   setpoint_q[$];

    logic [11:0] decay_r;
    logic [7:0]  first_gain_r;
    logic [7:0]  second_gain_r;
    logic [7:0]  brake_gain_r;
    logic [17:0] first_limit_r;
    logic [17:0] second_limit_r;

    int unsigned window_fill;
    int unsigned brake_total;
    int unsigned throttle_total;
    logic [17:0] speed_kept;

    function automatic int unsigned pedal_percent(logic [11:0] raw);
        int unsigned pct;
        pct = (32'(raw) * PEDAL_PCT_TOP) / PEDAL_FULL_SCALE;
        return (pct > PEDAL_PCT_TOP) ? PEDAL_PCT_TOP : pct;
    endfunction

    task automatic store_register(reg_index_t idx, logic [31:0] value);
        case (idx)
            REG_NEUTRAL_DECAY: decay_r        = value[11:0];
            REG_FIRST_GAIN:    first_gain_r   = value[7:0];
            REG_SECOND_GAIN:   second_gain_r  = value[7:0];
            REG_BRAKE_GAIN:    brake_gain_r   = value[7:0];
            REG_FIRST_LIMIT:   first_limit_r  = value[17:0];
            REG_SECOND_LIMIT:  second_limit_r = value[17:0];
            default:           ;
        endcase
    endtask

    task automatic check_register(reg_index_t idx, logic [31:0] value);
        logic [31:0] held;
        string       name;
        case (idx)
            REG_NEUTRAL_DECAY:
            begin
                held = 32'(decay_r);
                name = "neutral_decay";
            end
            REG_FIRST_GAIN:
            begin
                held = 32'(first_gain_r);
                name = "first_gain";
            end
            REG_SECOND_GAIN:
            begin
                held = 32'(second_gain_r);
                name = "second_gain";
            end
            REG_BRAKE_GAIN:
            begin
                held = 32'(brake_gain_r);
                name = "brake_gain";
            end
            REG_FIRST_LIMIT:
            begin
                held = 32'(first_limit_r);
                name = "first_limit";
            end
            REG_SECOND_LIMIT:
            begin
                held = 32'(second_limit_r);
                name = "second_limit";
            end
            default:
                return;
        endcase
        if (value !== held)
        begin
            $error("%s: expected %0d, got %0d", name, held, value);
            fail_count++;
        end
    endtask

    task automatic take_sample(logic [31:0] data);
        int unsigned b_avg;
        int unsigned t_avg;
        int unsigned gain;
        int          limit;
        int          s;
        gear_t       gear;
        setpoint_t   upd;
        brake_total    += pedal_percent(data[11:0]);
        throttle_total += pedal_percent(data[23:12]);
        window_fill++;
        if (window_fill < WINDOW)
        begin
            return;
        end
        b_avg          = brake_total / WINDOW;
        t_avg          = throttle_total / WINDOW;
        window_fill    = 0;
        brake_total    = 0;
        throttle_total = 0;
        if (data[24])
        begin
            gear = GEAR_NEUTRAL;
        end
        else if (data[25])
        begin
            gear = GEAR_SECOND;
        end
        else
        begin
            gear = GEAR_FIRST;
        end
        s = int'(speed_kept);
        if (gear == GEAR_NEUTRAL)
        begin
            s -= int'(decay_r);
            if (s < 0)
            begin
                s = 0;
            end
        end
        else
        begin
            gain  = (gear == GEAR_SECOND) ? second_gain_r : first_gain_r;
            limit = (gear == GEAR_SECOND) ? second_limit_r : first_limit_r;
            if (b_avg == 0 && t_avg > 0)
            begin
                s += int'(gain * t_avg);
            end
            else if (b_avg > 0 && t_avg == 0)
            begin
                s -= int'(brake_gain_r) * int'(b_avg);
            end
            if (s > limit)
            begin
                s = limit;
            end
            if (s < 0)
            begin
                s = 0;
            end
        end
        speed_kept       = 18'(s);
        upd.speed        = speed_kept;
        upd.brake_avg    = 7'(b_avg);
        upd.throttle_avg = 7'(t_avg);
        upd.gear         = gear;
        setpoint_q.push_back(upd);
    endtask

    task automatic compare_setpoint(logic [39:0] data);
        setpoint_t upd;
        if (setpoint_q.size() == 0)
        begin
            $error("speed result with no completed window: %h", data);
            fail_count++;
            return;
        end
        upd = setpoint_q.pop_front();
        results_checked++;
        if (data[17:0] !== upd.speed)
        begin
            $error("speed: expected %0d, got %0d", upd.speed, data[17:0]);
            fail_count++;
        end
        if (data[24:18] !== upd.brake_avg)
        begin
            $error("brake_average: expected %0d, got %0d", upd.brake_avg, data[24:18]);
            fail_count++;
        end
        if (data[31:25] !== upd.throttle_avg)
        begin
            $error("throttle_average: expected %0d, got %0d", upd.throttle_avg, data[31:25]);
            fail_count++;
        end
        if (data[33:32] !== upd.gear)
        begin
            $error("gear_used: expected %0d, got %0d", upd.gear, data[33:32]);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            decay_r         = RST_NEUTRAL_DECAY;
            first_gain_r    = RST_FIRST_GAIN;
            second_gain_r   = RST_SECOND_GAIN;
            brake_gain_r    = RST_BRAKE_GAIN;
            first_limit_r   = RST_FIRST_LIMIT;
            second_limit_r  = RST_SECOND_LIMIT;
            window_fill     = 0;
            brake_total     = 0;
            throttle_total  = 0;
            speed_kept      = '0;
            fail_count      = 0;
            samples_taken   = 0;
            results_checked = 0;
            setpoint_q.delete();
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    store_register(reg_index_t'(paddr[4:2]), pwdata);
                end
                else
                begin
                    check_register(reg_index_t'(paddr[4:2]), prdata);
                end
            end
            if (s_tvalid && s_tready)
            begin
                take_sample(s_tdata);
                samples_taken++;
            end
            if (m_tvalid && m_tready)
            begin
                compare_setpoint(m_tdata);
            end
        end
        pending = setpoint_q.size();
    end

endmodule

// ===== tb/pedal_gear_speed_setpoint_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the pedal and gear speed setpoint block: drives samples and
// register accesses, stalls the result side, and reports the verdict.
// Depends on pgss_pkg, pedal_gear_speed_setpoint_top and pedal_gear_speed_setpoint_monitor.
module pedal_gear_speed_setpoint_top_tb;
    import pgss_pkg::*;

    localparam int WINDOW        = 16;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 6;

    localparam reg_index_t REG_SPARE_LO = 3'd6;
    localparam reg_index_t REG_SPARE_HI = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int samples_taken;
    int results_checked;
    int setting_count;
    bit quiet;
    bit hold_request;

    always #10 clk = ~clk;

    pedal_gear_speed_setpoint_top #(
        .WINDOW (WINDOW)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    pedal_gear_speed_setpoint_monitor #(
        .WINDOW (WINDOW)
    ) monitor (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .fail_count      (fail_count),
        .pending         (pending),
        .samples_taken   (samples_taken),
        .results_checked (results_checked)
    );

    initial
    begin : result_side
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (quiet)
            begin
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= 8);
            end
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("FAIL");
        $finish;
    end

    function automatic logic [11:0] pedal_raw(bit pressed);
        logic [11:0] corners [6];
        corners = '{12'd41, 12'd2048, 12'd4080, 12'd4081, 12'd4082, 12'd4095};
        if (!pressed)
        begin
            return 12'($urandom_range(40, 0));
        end
        if ($urandom_range(3) == 0)
        begin
            return corners[$urandom_range(5)];
        end
        return 12'($urandom_range(4095, 41));
    endfunction

    task automatic offer_sample(logic [11:0] brake, logic [11:0] throttle,
                                logic neutral, logic second);
        int gap;
        if (!quiet && $urandom_range(99) < 3)
        begin
            gap = $urandom_range(4, 1);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, second, neutral, throttle, brake};
        do @(posedge clk); while (!s_tready);
    endtask

    // pedal pattern per window: throttle only, brake only, both, neither, or raw noise
    task automatic run_windows(int count);
        int   mode;
        int   pick;
        bit   noise;
        bit   brake_on;
        bit   throttle_on;
        logic neutral;
        logic second;
        repeat (count)
        begin
            mode        = $urandom_range(99);
            noise       = (mode >= 90);
            throttle_on = (mode < 35) || (mode >= 60 && mode < 75);
            brake_on    = (mode >= 35 && mode < 75);
            pick        = $urandom_range(99);
            neutral     = (pick < 25);
            second      = (pick < 25) ? 1'($urandom_range(1)) : (pick < 65);
            for (int i = 0; i < WINDOW; i++)
            begin
                offer_sample(noise ? 12'($urandom) : pedal_raw(brake_on),
                             noise ? 12'($urandom) : pedal_raw(throttle_on),
                             (i == WINDOW - 1) ? neutral : 1'($urandom_range(1)),
                             (i == WINDOW - 1) ? second : 1'($urandom_range(1)));
            end
        end
    endtask

    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apb_access(reg_index_t idx, logic write, logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic read_all();
        for (int i = REG_NEUTRAL_DECAY; i <= REG_SECOND_LIMIT; i++)
        begin
            apb_access(reg_index_t'(i), 1'b0, 32'b0);
        end
    endtask

    task automatic load_settings(logic [31:0] decay, logic [31:0] first_gain,
                                 logic [31:0] second_gain, logic [31:0] brake_gain,
                                 logic [31:0] first_limit, logic [31:0] second_limit);
        apb_access(REG_NEUTRAL_DECAY, 1'b1, decay);
        apb_access(REG_FIRST_GAIN, 1'b1, first_gain);
        apb_access(REG_SECOND_GAIN, 1'b1, second_gain);
        apb_access(REG_BRAKE_GAIN, 1'b1, brake_gain);
        apb_access(REG_FIRST_LIMIT, 1'b1, first_limit);
        apb_access(REG_SECOND_LIMIT, 1'b1, second_limit);
        read_all();
        setting_count++;
    endtask

    initial
    begin : stimulus
        logic [11:0] throttle_corner [16];
        logic [11:0] brake_corner [16];
        throttle_corner = '{12'd0, 12'd1, 12'd40, 12'd41, 12'd81, 12'd82, 12'd2040, 12'd2048,
                            12'd4080, 12'd4081, 12'd4082, 12'd4094, 12'd4095, 12'hAAA,
                            12'h555, 12'h7FF};
        brake_corner    = '{12'd0, 12'd40, 12'd1, 12'd2, 12'd4, 12'd8, 12'd16, 12'd32,
                            12'd39, 12'd21, 12'd10, 12'd0, 12'd40, 12'd5, 12'd3, 12'd0};
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        quiet         = 1'b0;
        hold_request  = 1'b0;
        setting_count = 1;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        read_all();
        for (int i = 0; i < WINDOW; i++)
        begin
            offer_sample(brake_corner[i], throttle_corner[i],
                         (i < WINDOW - 1) && i[0], (i < WINDOW - 1) && i[1]);
        end
        run_windows(5);

        settle();
        apb_access(REG_SPARE_LO, 1'b1, $urandom);
        apb_access(REG_SPARE_HI, 1'b1, $urandom);
        load_settings('1, '1, '1, '1, '1, '1);
        quiet        = 1'b1;
        hold_request = 1'b1;
        run_windows(3);
        quiet = 1'b0;
        run_windows(3);

        settle();
        load_settings($urandom_range(4095), $urandom_range(255), $urandom_range(255),
                      $urandom_range(255), $urandom_range(3000), $urandom_range(3000));
        run_windows(5);

        settle();
        load_settings('0, '0, '0, '0, '0, '0);
        run_windows(4);

        settle();
        load_settings($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        quiet = 1'b1;
        run_windows(3);
        quiet = 1'b0;
        run_windows(3);

        settle();
        load_settings(RST_NEUTRAL_DECAY, RST_FIRST_GAIN, RST_SECOND_GAIN, RST_BRAKE_GAIN,
                      RST_FIRST_LIMIT, RST_SECOND_LIMIT);
        run_windows(5);
        settle();

        $display("Ran %0d samples through %0d speed updates under %0d register settings,",
                 samples_taken, results_checked, setting_count);
        $display("with every gear and pedal pattern, saturated samples and a long result stall.");
        if (fail_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/pgss_pkg.sv
rtl/core/pedal_gear_speed_setpoint_top.sv
tb/pedal_gear_speed_setpoint_monitor.sv
tb/pedal_gear_speed_setpoint_top_tb.sv
